// ===== hw/rtl/kdsc_pkg.sv =====
// Shared types and constants for the keypad DAC setpoint controller.
// Used by every module under hw/rtl; depends on nothing.
package kdsc_pkg;

  localparam int CFG_W  = 12;
  localparam int MV_W   = 12;
  localparam int CODE_W = 8;
  localparam int NUM_W  = 20;  // holds 4095 * 255 + 2047

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [2:0] REG_REPEAT_DELAY = 3'd2;
  localparam logic [2:0] REG_REPEAT_PER   = 3'd3;
  localparam logic [2:0] REG_MAX_MV       = 3'd4;
  localparam logic [2:0] REG_FULL_SCALE   = 3'd5;

  localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 12'd40;
  localparam logic [CFG_W-1:0] RST_LONG_PRESS   = 12'd650;
  localparam logic [CFG_W-1:0] RST_REPEAT_DELAY = 12'd450;
  localparam logic [CFG_W-1:0] RST_REPEAT_PER   = 12'd90;
  localparam logic [CFG_W-1:0] RST_MAX_MV       = 12'd2000;
  localparam logic [CFG_W-1:0] RST_FULL_SCALE   = 12'd3300;

  localparam logic [1:0]        RST_STEP_SEL = 2'd1;
  localparam logic [CODE_W-1:0] CODE_MAX     = 8'd255;

  localparam logic [MV_W-1:0] STEP_MV [4] = '{12'd50, 12'd100, 12'd200, 12'd500};

  typedef struct packed {
    logic enter_level;
    logic cycle_level;
    logic back_level;
    logic off_level;
    logic force_off;
  } tick_t;

  typedef struct packed {
    logic [CODE_W-1:0] dac_code;
    logic [MV_W-1:0]   setpoint_mv;
    logic              output_on;
    logic [1:0]        step_select;
    logic              changed;
  } res_t;

  // Active-high key-down view of one tick, built by the front end.
  typedef struct packed {
    logic enter_dn;
    logic cycle_dn;
    logic back_dn;
    logic off_dn;
    logic force_off;
  } key_evt_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] repeat_delay_ticks;
    logic [CFG_W-1:0] repeat_period_ticks;
    logic [CFG_W-1:0] max_setpoint_mv;
    logic [CFG_W-1:0] full_scale_mv;
  } cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_CODE
  } back_state_e;

endpackage

// ===== hw/rtl/kdsc_front.sv =====
// Front end: classifies incoming ticks into key-down events and queues them.
// Two-entry queue; uses kdsc_pkg.
module kdsc_front import kdsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tick_t    tick_i,
  output logic     full_o,
  output logic     evt_valid_o,
  input  logic     evt_ready_i,
  output key_evt_t evt_o
);

  key_evt_t   ev_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  key_evt_t   ev_in;

  assign full_o      = (cnt_q == 2'd2);
  assign evt_valid_o = (cnt_q != 2'd0);
  assign evt_o       = ev_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = evt_valid_o && evt_ready_i;

  always_comb begin
    ev_in.enter_dn  = ~tick_i.enter_level;
    ev_in.cycle_dn  = ~tick_i.cycle_level;
    ev_in.back_dn   = ~tick_i.back_level;
    ev_in.off_dn    = ~tick_i.off_level;
    ev_in.force_off = tick_i.force_off;
  end

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ev_q[wr_ptr_q] <= ev_in;
    end
  end

endmodule

// ===== hw/rtl/kdsc_div.sv =====
// DAC code unit: rounded min(mv, max) * 255 / full_scale, saturated at 255.
// Forms the numerator first, then two quotient bits a cycle; uses kdsc_pkg.
module kdsc_div import kdsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MV_W-1:0]   mv_i,
  input  logic [CFG_W-1:0]  max_i,
  input  logic [CFG_W-1:0]  fs_i,
  output logic              done_o,
  output logic [CODE_W-1:0] code_o
);

  logic              busy_q;
  logic [2:0]        cnt_q;
  logic [MV_W-1:0]   mv_q, max_q;
  logic [CFG_W-1:0]  fs_q;
  logic [NUM_W-1:0]  rem_q, d_q;
  logic [CODE_W-1:0] quo_q;
  logic              sat_q;

  logic [MV_W-1:0]   v;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  r1, r2, d_half;
  logic              b1, b0;

  always_comb begin
    v      = (mv_q < max_q) ? mv_q : max_q;
    num    = (NUM_W'(v) << 8) - NUM_W'(v) + NUM_W'(fs_q >> 1);
    b1     = (rem_q >= d_q);
    r1     = b1 ? rem_q - d_q : rem_q;
    d_half = d_q >> 1;
    b0     = (r1 >= d_half);
    r2     = b0 ? r1 - d_half : r1;
  end

  assign done_o = busy_q && (cnt_q == 3'd4);
  assign code_o = sat_q ? CODE_MAX : {quo_q[CODE_W-3:0], b1, b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 3'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd4) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mv_q  <= mv_i;
      max_q <= max_i;
      // zero full scale acts as one
      fs_q  <= (fs_i == '0) ? CFG_W'(1) : fs_i;
    end else if (busy_q) begin
      if (cnt_q == 3'd0) begin
        rem_q <= num;
        d_q   <= NUM_W'(fs_q) << 7;
        quo_q <= '0;
      end else begin
        if (cnt_q == 3'd1) begin
          sat_q <= ({1'b0, rem_q} >= {d_q, 1'b0});
        end
        rem_q <= r2;
        d_q   <= d_q >> 2;
        quo_q <= {quo_q[CODE_W-3:0], b1, b0};
      end
    end
  end

endmodule

// ===== hw/rtl/kdsc_back.sv =====
// Back end: key timers, setpoint and enable state, one tick at a time.
// Starts kdsc_div when the DAC code must be refreshed; uses kdsc_pkg.
module kdsc_back import kdsc_pkg::*; #(
  parameter int TIMER_WIDTH = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     evt_valid_i,
  output logic     evt_ready_o,
  input  key_evt_t evt_i,
  input  logic     out_free_i,
  output logic     res_valid_o,
  output res_t     res_o
);

  localparam int TW = TIMER_WIDTH;
  localparam int CW = (TW > CFG_W) ? TW : CFG_W;

  typedef struct packed {
    logic          stable;
    logic          last;
    logic [TW-1:0] timer;
    logic          press;
  } deb_t;

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] t);
    return (&t) ? t : t + TW'(1);
  endfunction

  // Stable and last sample are kept in key-down polarity.
  function automatic deb_t debounce(input logic dn, input logic stable, input logic last,
                                    input logic [TW-1:0] timer, input logic [CFG_W-1:0] lim);
    deb_t r;
    r.stable = stable;
    r.last   = last;
    r.press  = 1'b0;
    if (dn != last) begin
      r.last  = dn;
      r.timer = '0;
    end else begin
      r.timer = sat_inc(timer);
    end
    if ((CW'(r.timer) > CW'(lim)) && (dn != stable)) begin
      r.stable = dn;
      r.press  = dn;
    end
    return r;
  endfunction

  back_state_e st_q, st_d;

  logic          ent_stable_q, ent_last_q, off_stable_q, off_last_q;
  logic [TW-1:0] ent_timer_q, off_timer_q;
  logic          cyc_held_q, cyc_held_d;
  logic [TW-1:0] cyc_hold_q, cyc_hold_d, cyc_rep_q, cyc_rep_d;
  logic          bk_held_q, bk_held_d, bk_long_q, bk_long_d;
  logic [TW-1:0] bk_hold_q, bk_hold_d;
  logic [MV_W-1:0]   tgt_q, tgt_d;
  logic [1:0]        step_q, step_d;
  logic              en_q, en_d;
  logic [CODE_W-1:0] dac_q, dac_d;
  res_t              res_q;

  deb_t              ent_r, off_r;
  logic              fire_up, fire_dn, chg, en_k, need_code, accept;
  logic [MV_W-1:0]   step_mv, tgt_a, tgt_t;
  logic [MV_W:0]     sum_up;
  res_t              res_now;
  logic              div_done;
  logic [CODE_W-1:0] div_code;

  assign accept = (st_q == BK_IDLE) && evt_valid_i && out_free_i;

  always_comb begin
    step_mv = STEP_MV[step_q];

    // cycle key: fire on press, then auto-repeat
    fire_up    = 1'b0;
    cyc_held_d = cyc_held_q;
    cyc_hold_d = cyc_hold_q;
    cyc_rep_d  = cyc_rep_q;
    if (evt_i.cycle_dn) begin
      if (!cyc_held_q) begin
        cyc_held_d = 1'b1;
        cyc_hold_d = '0;
        cyc_rep_d  = '0;
        fire_up    = 1'b1;
      end else begin
        cyc_hold_d = sat_inc(cyc_hold_q);
        cyc_rep_d  = sat_inc(cyc_rep_q);
        if ((CW'(cyc_hold_d) >= CW'(cfg_i.repeat_delay_ticks)) &&
            (CW'(cyc_rep_d) >= CW'(cfg_i.repeat_period_ticks))) begin
          cyc_rep_d = '0;
          fire_up   = 1'b1;
        end
      end
    end else begin
      cyc_held_d = 1'b0;
    end
    sum_up = {1'b0, tgt_q} + {1'b0, step_mv};
    tgt_a  = tgt_q;
    if (fire_up) begin
      tgt_a = (sum_up > {1'b0, cfg_i.max_setpoint_mv}) ? cfg_i.max_setpoint_mv
                                                       : sum_up[MV_W-1:0];
    end

    // back key: step down on a short release
    fire_dn   = 1'b0;
    bk_held_d = bk_held_q;
    bk_long_d = bk_long_q;
    bk_hold_d = bk_hold_q;
    if (evt_i.back_dn) begin
      if (!bk_held_q) begin
        bk_held_d = 1'b1;
        bk_long_d = 1'b0;
        bk_hold_d = '0;
      end else begin
        bk_hold_d = sat_inc(bk_hold_q);
        if (CW'(bk_hold_d) >= CW'(cfg_i.long_press_ticks)) begin
          bk_long_d = 1'b1;
        end
      end
    end else if (bk_held_q) begin
      bk_hold_d = sat_inc(bk_hold_q);
      bk_held_d = 1'b0;
      fire_dn   = !bk_long_q && (CW'(bk_hold_d) > CW'(cfg_i.debounce_ticks));
    end
    tgt_t = (tgt_a > step_mv) ? tgt_a - step_mv : '0;
    tgt_d = tgt_a;
    if (fire_dn) begin
      tgt_d = (tgt_t > cfg_i.max_setpoint_mv) ? cfg_i.max_setpoint_mv : tgt_t;
    end

    ent_r = debounce(evt_i.enter_dn, ent_stable_q, ent_last_q, ent_timer_q,
                     cfg_i.debounce_ticks);
    off_r = debounce(evt_i.off_dn, off_stable_q, off_last_q, off_timer_q,
                     cfg_i.debounce_ticks);

    en_k   = en_q ^ ent_r.press;
    step_d = step_q + {1'b0, off_r.press};
    chg    = fire_up || fire_dn || ent_r.press || off_r.press;

    // force-off comes after the key handling
    en_d      = en_k && !evt_i.force_off;
    need_code = chg && en_k && !evt_i.force_off;
    dac_d     = (evt_i.force_off || chg) ? '0 : dac_q;

    res_now.dac_code    = dac_d;
    res_now.setpoint_mv = tgt_d;
    res_now.output_on   = en_d;
    res_now.step_select = step_d;
    res_now.changed     = chg || (evt_i.force_off && en_k);
  end

  always_comb begin
    st_d        = st_q;
    evt_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = res_now;
    case (st_q)
      BK_IDLE: begin
        evt_ready_o = out_free_i;
        if (accept) begin
          if (need_code) begin
            st_d = BK_CODE;
          end else begin
            res_valid_o = 1'b1;
          end
        end
      end
      BK_CODE: begin
        res_o          = res_q;
        res_o.dac_code = div_code;
        if (div_done) begin
          res_valid_o = 1'b1;
          st_d        = BK_IDLE;
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= BK_IDLE;
      ent_stable_q <= 1'b0;
      ent_last_q   <= 1'b0;
      ent_timer_q  <= '0;
      off_stable_q <= 1'b0;
      off_last_q   <= 1'b0;
      off_timer_q  <= '0;
      cyc_held_q   <= 1'b0;
      cyc_hold_q   <= '0;
      cyc_rep_q    <= '0;
      bk_held_q    <= 1'b0;
      bk_long_q    <= 1'b0;
      bk_hold_q    <= '0;
      tgt_q        <= '0;
      step_q       <= RST_STEP_SEL;
      en_q         <= 1'b0;
      dac_q        <= '0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        ent_stable_q <= ent_r.stable;
        ent_last_q   <= ent_r.last;
        ent_timer_q  <= ent_r.timer;
        off_stable_q <= off_r.stable;
        off_last_q   <= off_r.last;
        off_timer_q  <= off_r.timer;
        cyc_held_q   <= cyc_held_d;
        cyc_hold_q   <= cyc_hold_d;
        cyc_rep_q    <= cyc_rep_d;
        bk_held_q    <= bk_held_d;
        bk_long_q    <= bk_long_d;
        bk_hold_q    <= bk_hold_d;
        tgt_q        <= tgt_d;
        step_q       <= step_d;
        en_q         <= en_d;
        dac_q        <= dac_d;
      end else if ((st_q == BK_CODE) && div_done) begin
        dac_q <= div_code;
      end
    end
  end

  // hold the result fields while the code is computed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_now;
    end
  end

  kdsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && need_code),
    .mv_i    (tgt_d),
    .max_i   (cfg_i.max_setpoint_mv),
    .fs_i    (cfg_i.full_scale_mv),
    .done_o  (div_done),
    .code_o  (div_code)
  );

endmodule

// ===== hw/rtl/keypad_dac_setpoint_controller_top.sv =====
// Keypad DAC setpoint controller: APB register file, result register, and
// the front/back pipeline. Depends on kdsc_pkg, kdsc_front and kdsc_back.
//
// Each pushed item is one millisecond keypad tick; each produces exactly one
// result in order. A tick that leaves the DAC code as it was, or forces it to
// zero, gives its result in the same cycle as the back end takes it. A tick
// that changes a setting while the output is on goes through these steps: the
// back end takes the tick, a step forms the rounded numerator, and four steps
// of the radix-4 restoring divider yield the 8-bit code. A two-entry input
// queue and a one-entry result register buffer items when either side stalls.
// Configuration registers, 12 bits wide, sit at byte addresses 0, 4, ... 20.
module keypad_dac_setpoint_controller_top import kdsc_pkg::*; #(
  parameter int TIMER_WIDTH = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  tick_t             tick_i,
  output logic              empty,
  input  logic              pop,
  output res_t              res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic [CFG_W-1:0] rd_val;
  logic       cfg_wr;

  logic       evt_valid, evt_ready;
  key_evt_t   evt;
  logic       res_valid, out_free;
  res_t       res_new;
  logic       out_valid_q;
  res_t       out_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:     rd_val = cfg_q.debounce_ticks;
      REG_LONG_PRESS:   rd_val = cfg_q.long_press_ticks;
      REG_REPEAT_DELAY: rd_val = cfg_q.repeat_delay_ticks;
      REG_REPEAT_PER:   rd_val = cfg_q.repeat_period_ticks;
      REG_MAX_MV:       rd_val = cfg_q.max_setpoint_mv;
      REG_FULL_SCALE:   rd_val = cfg_q.full_scale_mv;
      default:          rd_val = '0;
    endcase
  end
  assign prdata = DATA_W'(rd_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks      <= RST_DEBOUNCE;
      cfg_q.long_press_ticks    <= RST_LONG_PRESS;
      cfg_q.repeat_delay_ticks  <= RST_REPEAT_DELAY;
      cfg_q.repeat_period_ticks <= RST_REPEAT_PER;
      cfg_q.max_setpoint_mv     <= RST_MAX_MV;
      cfg_q.full_scale_mv       <= RST_FULL_SCALE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE:     cfg_q.debounce_ticks      <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS:   cfg_q.long_press_ticks    <= pwdata[CFG_W-1:0];
        REG_REPEAT_DELAY: cfg_q.repeat_delay_ticks  <= pwdata[CFG_W-1:0];
        REG_REPEAT_PER:   cfg_q.repeat_period_ticks <= pwdata[CFG_W-1:0];
        REG_MAX_MV:       cfg_q.max_setpoint_mv     <= pwdata[CFG_W-1:0];
        REG_FULL_SCALE:   cfg_q.full_scale_mv       <= pwdata[CFG_W-1:0];
        default:          ;
      endcase
    end
  end

  kdsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .tick_i      (tick_i),
    .full_o      (full),
    .evt_valid_o (evt_valid),
    .evt_ready_i (evt_ready),
    .evt_o       (evt)
  );

  kdsc_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .evt_valid_i (evt_valid),
    .evt_ready_o (evt_ready),
    .evt_i       (evt),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res_new)
  );

  // the back end starts a tick only when its result has a place to land
  assign out_free = !out_valid_q || pop;
  assign empty    = !out_valid_q;
  assign res_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res_new;
    end
  end

endmodule
